### rtl/icon_box_downscale_alpha_test_assert.svh
// Assertion macros for the icon box downscaler.
// Taken in by the top level; expand to nothing under synthesis.
`ifndef ICON_BOX_DOWNSCALE_ALPHA_TEST_ASSERT_SVH
`define ICON_BOX_DOWNSCALE_ALPHA_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define IBDAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibdat: same-cycle check failed");
`define IBDAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibdat: next-cycle check failed");
`else
`define IBDAT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IBDAT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ibdat_pkg.sv
// Shared constants, codes and types of the icon box downscaler.
// Used by the sequencer, the divider and the top level.
package ibdat_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int IDX_W       = 12;
    localparam int ARGB_W      = 32;
    localparam int COORD_W     = 6;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + CH_W;
    localparam int NUM_W       = (SUM_W > COORD_W + SIDE_W) ? SUM_W : COORD_W + SIDE_W;
    localparam int DEN_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DCNT_W      = $clog2(NUM_W + 1);
    localparam int ALPHA_LIMIT = 128;

    localparam int IN_DATA_W   = 56;
    localparam int IDX_LSB     = 0;
    localparam int ARGB_LSB    = IDX_LSB + IDX_W;
    localparam int COL_LSB     = ARGB_LSB + ARGB_W;
    localparam int ROW_LSB     = COL_LSB + COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_SIDE = 1'd1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CFG_W-1:0] SRC_SIDE_RST = 7'd32;
    localparam logic [CFG_W-1:0] DST_SIDE_RST = 7'd16;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_query;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic             valid;
        logic             we;
        logic [RGB_W-1:0] rgb;
    } t_result;

endpackage

### rtl/ibdat_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ibdat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ibdat_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ibdat_pkg for widths and request/response types.
module ibdat_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ibdat_pkg::t_div_req i_req,
    output ibdat_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ibdat_pkg::DCNT_W-1:0]  r_cnt;
    logic [ibdat_pkg::NUM_W-1:0]   r_quot;
    logic [ibdat_pkg::DEN_W-1:0]   r_rem;
    logic [ibdat_pkg::DEN_W-1:0]   r_den;
    logic [ibdat_pkg::DEN_W:0]     w_trial;
    logic [ibdat_pkg::DEN_W:0]     w_diff;
    logic                          w_ge;

    assign w_trial = {r_rem, r_quot[ibdat_pkg::NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ibdat_pkg::DCNT_W'(ibdat_pkg::NUM_W);
                r_quot <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[ibdat_pkg::DEN_W-1:0] : w_trial[ibdat_pkg::DEN_W-1:0];
                r_quot <= {r_quot[ibdat_pkg::NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt - ibdat_pkg::DCNT_W'(1);
                if (r_cnt == ibdat_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### rtl/ibdat_seq.sv
// Query sequencer: window scan over the pixel memory, accumulation, averaging.
// Depends on ibdat_pkg and instantiates ibdat_div.
module ibdat_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ibdat_pkg::t_query            i_query,
    input  logic [ibdat_pkg::SIDE_W-1:0] i_src_side,
    input  logic [ibdat_pkg::CFG_W-1:0]  i_dst_side,
    output logic                         o_idle,
    output logic [ibdat_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [ibdat_pkg::ARGB_W-1:0] i_rd_data,
    input  logic                         i_out_ready,
    output ibdat_pkg::t_result           o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STEP  = 4'd1;
    localparam logic [3:0] S_SX    = 4'd2;
    localparam logic [3:0] S_SY    = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_DIV_A = 4'd7;
    localparam logic [3:0] S_DIV_R = 4'd8;
    localparam logic [3:0] S_DIV_G = 4'd9;
    localparam logic [3:0] S_DIV_B = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam int SW = ibdat_pkg::SIDE_W;
    localparam int MW = 2 * ibdat_pkg::SIDE_W;

    logic [3:0]                          r_state;
    logic [3:0]                          n_state;
    logic [ibdat_pkg::COORD_W-1:0]       r_col;
    logic [ibdat_pkg::COORD_W-1:0]       r_row;
    logic [SW-1:0]                       r_ss;
    logic [ibdat_pkg::CFG_W-1:0]         r_ds;
    logic [SW-1:0]                       r_step;
    logic [SW-1:0]                       r_sx;
    logic [SW-1:0]                       r_yy;
    logic [SW-1:0]                       r_xx;
    logic [SW-1:0]                       r_y_end;
    logic [SW-1:0]                       r_x_end;
    logic                                r_rd_vld;
    logic [ibdat_pkg::SUM_W-1:0]         r_sum_r;
    logic [ibdat_pkg::SUM_W-1:0]         r_sum_g;
    logic [ibdat_pkg::SUM_W-1:0]         r_sum_b;
    logic [ibdat_pkg::SUM_W-1:0]         r_sum_a;
    logic [ibdat_pkg::CNT_W-1:0]         r_cnt;
    logic                                r_res_we;
    logic [ibdat_pkg::RGB_W-1:0]         r_res_rgb;
    logic                                r_out_vld;
    logic                                r_out_we;
    logic [ibdat_pkg::RGB_W-1:0]         r_out_rgb;

    ibdat_pkg::t_div_req                 w_div_req;
    ibdat_pkg::t_div_rsp                 w_div_rsp;
    logic                                w_bad;
    logic [SW-1:0]                       w_q_side;
    logic [SW:0]                         w_ysum;
    logic [SW:0]                         w_xsum;
    logic [MW-1:0]                       w_addr_full;
    logic [SW-1:0]                       w_xx_nxt;
    logic [SW-1:0]                       w_yy_nxt;
    logic                                w_px_hit;
    logic                                w_alpha_low;

    ibdat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_bad = (i_src_side == '0) || (i_dst_side == '0)
                || (ibdat_pkg::CFG_W'(i_query.col) >= i_dst_side)
                || (ibdat_pkg::CFG_W'(i_query.row) >= i_dst_side);

    assign w_q_side    = SW'(w_div_rsp.quot);
    assign w_ysum      = (SW+1)'(w_q_side) + (SW+1)'(r_step);
    assign w_xsum      = (SW+1)'(r_sx) + (SW+1)'(r_step);
    assign w_addr_full = MW'(r_yy) * MW'(r_ss) + MW'(r_xx);
    assign o_rd_addr   = ibdat_pkg::ADDR_W'(w_addr_full);
    assign w_xx_nxt    = r_xx + SW'(1);
    assign w_yy_nxt    = r_yy + SW'(1);
    assign w_px_hit    = i_rd_data[ibdat_pkg::ARGB_W-1 -: ibdat_pkg::CH_W]
                       > ibdat_pkg::CH_W'(ibdat_pkg::ALPHA_LIMIT);
    assign w_alpha_low = w_div_rsp.quot <= ibdat_pkg::NUM_W'(ibdat_pkg::ALPHA_LIMIT);

    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        case (r_state)
            S_IDLE: begin
                if (i_query.valid) begin
                    if (w_bad) begin
                        n_state = S_OUT;
                    end else begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = ibdat_pkg::NUM_W'(i_src_side);
                        w_div_req.den   = ibdat_pkg::DEN_W'(i_dst_side);
                        n_state         = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ibdat_pkg::NUM_W'(r_col) * ibdat_pkg::NUM_W'(r_ss);
                    w_div_req.den   = ibdat_pkg::DEN_W'(r_ds);
                    n_state         = S_SX;
                end
            end
            S_SX: begin
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ibdat_pkg::NUM_W'(r_row) * ibdat_pkg::NUM_W'(r_ss);
                    w_div_req.den   = ibdat_pkg::DEN_W'(r_ds);
                    n_state         = S_SY;
                end
            end
            S_SY: begin
                if (w_div_rsp.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_xx_nxt == r_x_end && w_yy_nxt == r_y_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ibdat_pkg::NUM_W'(r_sum_a);
                    w_div_req.den   = ibdat_pkg::DEN_W'(r_cnt);
                    n_state         = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (w_div_rsp.done) begin
                    if (w_alpha_low) begin
                        n_state = S_OUT;
                    end else begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = ibdat_pkg::NUM_W'(r_sum_r);
                        w_div_req.den   = ibdat_pkg::DEN_W'(r_cnt);
                        n_state         = S_DIV_R;
                    end
                end
            end
            S_DIV_R: begin
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ibdat_pkg::NUM_W'(r_sum_g);
                    w_div_req.den   = ibdat_pkg::DEN_W'(r_cnt);
                    n_state         = S_DIV_G;
                end
            end
            S_DIV_G: begin
                if (w_div_rsp.done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ibdat_pkg::NUM_W'(r_sum_b);
                    w_div_req.den   = ibdat_pkg::DEN_W'(r_cnt);
                    n_state         = S_DIV_B;
                end
            end
            S_DIV_B: begin
                if (w_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_READ);
            if (r_out_vld && i_out_ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            if (r_rd_vld && w_px_hit) begin
                r_sum_r <= r_sum_r + ibdat_pkg::SUM_W'(i_rd_data[23:16]);
                r_sum_g <= r_sum_g + ibdat_pkg::SUM_W'(i_rd_data[15:8]);
                r_sum_b <= r_sum_b + ibdat_pkg::SUM_W'(i_rd_data[7:0]);
                r_sum_a <= r_sum_a + ibdat_pkg::SUM_W'(i_rd_data[31:24]);
                r_cnt   <= r_cnt + ibdat_pkg::CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    r_col     <= i_query.col;
                    r_row     <= i_query.row;
                    r_ss      <= i_src_side;
                    r_ds      <= i_dst_side;
                    r_res_we  <= 1'b0;
                    r_res_rgb <= '0;
                end
                S_STEP: begin
                    if (w_div_rsp.done) begin
                        r_step <= (w_q_side == '0) ? SW'(1) : w_q_side;
                    end
                end
                S_SX: begin
                    if (w_div_rsp.done) begin
                        r_sx <= w_q_side;
                        r_xx <= w_q_side;
                    end
                end
                S_SY: begin
                    if (w_div_rsp.done) begin
                        r_yy    <= w_q_side;
                        r_y_end <= (w_ysum > (SW+1)'(r_ss)) ? r_ss : SW'(w_ysum);
                        r_x_end <= (w_xsum > (SW+1)'(r_ss)) ? r_ss : SW'(w_xsum);
                        r_sum_r <= '0;
                        r_sum_g <= '0;
                        r_sum_b <= '0;
                        r_sum_a <= '0;
                        r_cnt   <= '0;
                    end
                end
                S_READ: begin
                    if (w_xx_nxt == r_x_end) begin
                        r_xx <= r_sx;
                        r_yy <= w_yy_nxt;
                    end else begin
                        r_xx <= w_xx_nxt;
                    end
                end
                S_DIV_R: begin
                    if (w_div_rsp.done) begin
                        r_res_rgb[23:16] <= w_div_rsp.quot[ibdat_pkg::CH_W-1:0];
                    end
                end
                S_DIV_G: begin
                    if (w_div_rsp.done) begin
                        r_res_rgb[15:8] <= w_div_rsp.quot[ibdat_pkg::CH_W-1:0];
                    end
                end
                S_DIV_B: begin
                    if (w_div_rsp.done) begin
                        r_res_rgb[7:0] <= w_div_rsp.quot[ibdat_pkg::CH_W-1:0];
                        r_res_we       <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld <= 1'b1;
                        r_out_we  <= r_res_we;
                        r_out_rgb <= r_res_we ? r_res_rgb : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.we    = r_out_we;
    assign o_out.rgb   = r_out_rgb;

endmodule

### rtl/icon_box_downscale_alpha_test.sv
// Top level of the icon box downscaler: configuration registers, pixel store, stream ports.
// Depends on ibdat_pkg, ibdat_ram, ibdat_seq and the assertion header.
//
// Use: configure source_side (index 0) and dest_side (index 1) on the write port while
// the block is idle. Requests arrive on s_axis: tuser selects a load (0) or a query (1).
// A load writes one ARGB pixel into the 4096-entry store; it gives
// no result. A query averages the step x step window of opaque-enough source pixels for
// one destination pixel and returns one result on m_axis: tuser is the write flag, tdata
// the mean RGB (zero when the flag is low).
// A query for a pixel outside the destination or with a zero side skips the divisions
// and returns an empty result; otherwise a painted pixel takes seven divisions on the
// shared one-bit-per-cycle divider plus one store read per window pixel, and fewer
// divisions when no pixel counts or the mean alpha is too low.
// One request is worked on at a time; the next is taken once the result sits in the
// output register, so a stalled receiver only holds the block after a second result.
// Reset sets source_side to 32, dest_side to 16 and empties the output; the store is
// not cleared and must be loaded before it is queried.
module icon_box_downscale_alpha_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ibdat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ibdat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // source_index[11:0], source_argb[43:12], dest_col[49:44], dest_row[55:50]
    input  logic [ibdat_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // req_type[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // averaged_rgb[23:0]
    output logic [ibdat_pkg::RGB_W-1:0]     m_axis_tdata,
    // write_enable[0]
    output logic                            m_axis_tuser
);

`include "icon_box_downscale_alpha_test_assert.svh"

    logic [ibdat_pkg::CFG_W-1:0]   r_src_side;
    logic [ibdat_pkg::CFG_W-1:0]   r_dst_side;
    logic [ibdat_pkg::SIDE_W-1:0]  w_ss;
    logic                          w_accept;
    logic                          w_load;
    logic [ibdat_pkg::IDX_W-1:0]   w_idx;
    ibdat_pkg::t_query             w_query;
    logic                          w_idle;
    logic [ibdat_pkg::ADDR_W-1:0]  w_rd_addr;
    logic [ibdat_pkg::ARGB_W-1:0]  w_rd_data;
    ibdat_pkg::t_result            w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_side <= ibdat_pkg::SRC_SIDE_RST;
            r_dst_side <= ibdat_pkg::DST_SIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ibdat_pkg::CFG_SRC_SIDE: r_src_side <= i_cfg_data;
                ibdat_pkg::CFG_DST_SIDE: r_dst_side <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_ss = (32'(r_src_side) > 32'(ibdat_pkg::MAX_SIDE))
                ? ibdat_pkg::SIDE_W'(ibdat_pkg::MAX_SIDE)
                : ibdat_pkg::SIDE_W'(r_src_side);

    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_idx         = s_axis_tdata[ibdat_pkg::IDX_LSB +: ibdat_pkg::IDX_W];
    assign w_load        = w_accept && (s_axis_tuser == ibdat_pkg::REQ_LOAD)
                        && (32'(w_idx) < 32'(ibdat_pkg::STORE_DEPTH));

    assign w_query.valid = w_accept && (s_axis_tuser == ibdat_pkg::REQ_QUERY);
    assign w_query.col   = s_axis_tdata[ibdat_pkg::COL_LSB +: ibdat_pkg::COORD_W];
    assign w_query.row   = s_axis_tdata[ibdat_pkg::ROW_LSB +: ibdat_pkg::COORD_W];

    ibdat_ram #(
        .WIDTH (ibdat_pkg::ARGB_W),
        .DEPTH (ibdat_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (ibdat_pkg::ADDR_W'(w_idx)),
        .i_wr_data (s_axis_tdata[ibdat_pkg::ARGB_LSB +: ibdat_pkg::ARGB_W]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ibdat_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query     (w_query),
        .i_src_side  (w_ss),
        .i_dst_side  (r_dst_side),
        .o_idle      (w_idle),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tvalid = w_out.valid;
    assign m_axis_tuser  = w_out.we;
    assign m_axis_tdata  = w_out.rgb;

    `IBDAT_ASSERT_NXT(a_query_holds_input, i_clk, i_rst_n, w_query.valid, !s_axis_tready)
    `IBDAT_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, w_accept && !w_query.valid, s_axis_tready)
    `IBDAT_ASSERT_IMP(a_result_after_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))
    `IBDAT_ASSERT_IMP(a_no_paint_zero_rgb, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

endmodule

### tb/sv/icon_box_downscale_alpha_test_tb.sv
// Self-checking bench for icon_box_downscale_alpha_test: loads source icons, queries
// destination pixels under many side settings and compares each result with its own model.
// Depends on ibdat_pkg and the top level of the block.
module icon_box_downscale_alpha_test_tb;
    import ibdat_pkg::*;

    localparam int ITEM_TARGET = 935;
    localparam int STUCK_LIMIT = 20000;
    localparam int LONG_HOLD   = 600;

    typedef struct packed {
        logic             we;
        logic [RGB_W-1:0] rgb;
    } t_paint;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_SRC_SIDE;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = REQ_LOAD;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [RGB_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;

    logic [ARGB_W-1:0] icon_store [STORE_DEPTH];
    bit                icon_loaded [STORE_DEPTH];
    logic [CFG_W-1:0]  src_side_cfg = SRC_SIDE_RST;
    logic [CFG_W-1:0]  dst_side_cfg = DST_SIDE_RST;
    t_paint            paint_due [$];
    t_paint            oldest_paint;

    int burst_left    = 0;
    int items_sent    = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int painted_seen  = 0;
    int settings_seen = 0;
    int fail_count    = 0;
    int stuck_cycles  = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [3:0]  rx_phase   = '0;

    icon_box_downscale_alpha_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit window_of(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                     output int unsigned ss, output int unsigned step,
                                     output int unsigned sx, output int unsigned sy);
        int unsigned ds;
        ss   = (src_side_cfg > CFG_W'(MAX_SIDE)) ? MAX_SIDE : 32'(src_side_cfg);
        ds   = 32'(dst_side_cfg);
        step = 1;
        sx   = 0;
        sy   = 0;
        if (ss == 0 || ds == 0 || 32'(col) >= ds || 32'(row) >= ds) return 1'b0;
        step = (ss / ds < 1) ? 1 : ss / ds;
        sx   = 32'(col) * ss / ds;
        sy   = 32'(row) * ss / ds;
        return 1'b1;
    endfunction

    function automatic t_paint average_window(input logic [COORD_W-1:0] col,
                                              input logic [COORD_W-1:0] row);
        int unsigned ss, step, sx, sy, yy, xx, cnt;
        int unsigned sum_a, sum_r, sum_g, sum_b, avg_r, avg_g, avg_b;
        logic [ARGB_W-1:0] px;
        t_paint res;
        res   = '0;
        cnt   = 0;
        sum_a = 0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        if (!window_of(col, row, ss, step, sx, sy)) return res;
        for (yy = sy; yy < sy + step && yy < ss; yy++) begin
            for (xx = sx; xx < sx + step && xx < ss; xx++) begin
                px = icon_store[yy * ss + xx];
                if (32'(px[31:24]) > ALPHA_LIMIT) begin
                    sum_a += 32'(px[31:24]);
                    sum_r += 32'(px[23:16]);
                    sum_g += 32'(px[15:8]);
                    sum_b += 32'(px[7:0]);
                    cnt++;
                end
            end
        end
        if (cnt == 0 || sum_a / cnt <= ALPHA_LIMIT) return res;
        avg_r   = sum_r / cnt;
        avg_g   = sum_g / cnt;
        avg_b   = sum_b / cnt;
        res.we  = 1'b1;
        res.rgb = {avg_r[7:0], avg_g[7:0], avg_b[7:0]};
        return res;
    endfunction

    function automatic logic [ARGB_W-1:0] rand_argb();
        logic [7:0] alpha;
        case ($urandom_range(0, 5))
            0:       alpha = 8'($urandom_range(0, ALPHA_LIMIT));
            1:       alpha = 8'(ALPHA_LIMIT);
            2:       alpha = 8'(ALPHA_LIMIT + 1);
            3:       alpha = 8'hFF;
            default: alpha = 8'($urandom_range(ALPHA_LIMIT + 1, 255));
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    task automatic push_request(input logic kind, input logic [IDX_W-1:0] idx,
                                input logic [ARGB_W-1:0] argb, input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {row, col, argb, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
        if (kind == REQ_LOAD) begin
            icon_store[idx]  = argb;
            icon_loaded[idx] = 1'b1;
            loads_sent++;
        end else begin
            paint_due.push_back(average_window(col, row));
            queries_sent++;
        end
    endtask

    task automatic load_pixel(input logic [IDX_W-1:0] idx, input logic [ARGB_W-1:0] argb);
        push_request(REQ_LOAD, idx, argb, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // load any unwritten pixel of the window first, then send the query
    task automatic query_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        int unsigned ss, step, sx, sy, yy, xx;
        if (window_of(col, row, ss, step, sx, sy)) begin
            for (yy = sy; yy < sy + step && yy < ss; yy++) begin
                for (xx = sx; xx < sx + step && xx < ss; xx++) begin
                    if (!icon_loaded[yy * ss + xx]) load_pixel(IDX_W'(yy * ss + xx), rand_argb());
                end
            end
        end
        push_request(REQ_QUERY, IDX_W'($urandom), $urandom, col, row);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (paint_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_sides(input logic [CFG_W-1:0] src_side, input logic [CFG_W-1:0] dst_side);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SRC_SIDE;
        i_cfg_data  <= src_side;
        @(posedge i_clk);
        src_side_cfg = src_side;
        i_cfg_index <= CFG_DST_SIDE;
        i_cfg_data  <= dst_side;
        @(posedge i_clk);
        dst_side_cfg = dst_side;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        settings_seen++;
    endtask

    task automatic test_alpha_edges();
        load_pixel(0, 32'hFF102030);
        load_pixel(1, 32'h80FFFFFF);
        load_pixel(32, 32'h81010203);
        load_pixel(33, 32'h00FFFFFF);
        query_pixel(0, 0);
        load_pixel(2, 32'h80000000);
        load_pixel(3, 32'h80FFFFFF);
        load_pixel(34, 32'h80123456);
        load_pixel(35, 32'h7FFFFFFF);
        query_pixel(1, 0);
        load_pixel(4095, 32'hFFFFFFFF);
        query_pixel(15, 15);
        query_pixel(16, 0);
        query_pixel(63, 63);
    endtask

    task automatic test_side_extremes();
        set_sides(64, 64);
        query_pixel(63, 63);
        query_pixel(0, 0);
        set_sides(1, 1);
        query_pixel(0, 0);
        set_sides(1, 64);
        query_pixel(63, 0);
        set_sides(0, 16);
        query_pixel(2, 2);
        set_sides(32, 0);
        query_pixel(0, 0);
        set_sides(100, 64);
        query_pixel(1, 0);
        set_sides(2, 1);
        query_pixel(0, 0);
    endtask

    task automatic test_random_scaling();
        int unsigned src_side, dst_side, src_eff, phase_end, pick, phase;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0:       begin src_side = 64; dst_side = 8;  end
                1:       begin src_side = 8;  dst_side = 1;  end
                2:       begin src_side = 1;  dst_side = 64; end
                3:       begin src_side = 64; dst_side = 64; end
                4:       begin src_side = 1;  dst_side = 1;  end
                5:       begin src_side = 32; dst_side = 16; end
                default: begin
                    dst_side = $urandom_range(1, 64);
                    src_side = $urandom_range(1, (9 * dst_side - 1 > 64) ? 64 : 9 * dst_side - 1);
                end
            endcase
            phase++;
            set_sides(CFG_W'(src_side), CFG_W'(dst_side));
            src_eff   = src_side;
            phase_end = items_sent + $urandom_range(60, 120);
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    query_pixel(COORD_W'($urandom_range(0, dst_side - 1)),
                                COORD_W'($urandom_range(0, dst_side - 1)));
                else if (pick < 70)
                    query_pixel(COORD_W'($urandom), COORD_W'($urandom));
                else if (pick < 85)
                    load_pixel(IDX_W'($urandom_range(0, src_eff * src_eff - 1)), rand_argb());
                else
                    load_pixel(IDX_W'($urandom), $urandom);
            end
        end
    endtask

    // hold the result side off long enough for the block to stall its input
    task automatic test_output_stall();
        int n;
        set_sides(32, 16);
        hold_asks++;
        for (n = 0; n < 12; n++)
            query_pixel(COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)));
    endtask

    task automatic wrap_up();
        settle();
        repeat (300) @(posedge i_clk);
        if (paint_due.size() != 0) begin
            $error("%0d query results never arrived", paint_due.size());
            fail_count++;
        end
        $display("Covered %0d loads and %0d queries (%0d painted) across %0d side settings.",
                 loads_sent, queries_sent, painted_seen, settings_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alpha_edges();
        test_side_extremes();
        test_random_scaling();
        test_output_stall();
        wrap_up();
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= hold_asks;
            hold_left     <= LONG_HOLD;
        end else begin
            m_axis_tready <= rx_pattern[rx_phase];
            rx_phase      <= rx_phase + 4'd1;
            if (rx_phase == 4'hF)
                rx_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (paint_due.size() == 0) begin
                $error("result with no query outstanding: write_enable %0d, averaged_rgb %06h",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                oldest_paint = paint_due.pop_front();
                if (oldest_paint.we) painted_seen++;
                if (m_axis_tuser !== oldest_paint.we) begin
                    $error("write_enable: expected %0d, got %0d", oldest_paint.we, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata !== oldest_paint.rgb) begin
                    $error("averaged_rgb: expected %06h, got %06h", oldest_paint.rgb, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
